// ----- rtl/sctl_pkg.sv -----
// ----------------------------------------------------------------------------
// sctl_pkg
// types and constants for the source code token lexer
// ----------------------------------------------------------------------------
package sctl_pkg;

  typedef enum logic [11:0] {
    M_IDLE  = 12'b0000_0000_0001,
    M_IDENT = 12'b0000_0000_0010,
    M_INT   = 12'b0000_0000_0100,
    M_DOT   = 12'b0000_0000_1000,
    M_FRAC  = 12'b0000_0001_0000,
    M_STR   = 12'b0000_0010_0000,
    M_ESC   = 12'b0000_0100_0000,
    M_SLASH = 12'b0000_1000_0000,
    M_LINE  = 12'b0001_0000_0000,
    M_BLOCK = 12'b0010_0000_0000,
    M_BSTAR = 12'b0100_0000_0000,
    M_OP    = 12'b1000_0000_0000
  } mode_t;

  localparam logic [5:0] K_IDENT  = 6'd0;
  localparam logic [5:0] K_INT    = 6'd1;
  localparam logic [5:0] K_STRING = 6'd2;
  localparam logic [5:0] K_KW0    = 6'd3;
  localparam logic [5:0] K_DOT    = 6'd21;
  localparam logic [5:0] K_SLASH  = 6'd26;
  localparam logic [5:0] K_ARROW  = 6'd33;
  localparam logic [5:0] K_ERROR  = 6'd42;
  localparam logic [5:0] K_EOF    = 6'd43;

  localparam logic [1:0] E_NONE  = 2'd0;
  localparam logic [1:0] E_CHAR  = 2'd1;
  localparam logic [1:0] E_UNTERM = 2'd2;

  localparam int NUM_KW = 11;

  function automatic logic [47:0] kw_text(input logic [3:0] k);
    case (k)
      4'd0:    kw_text = 48'h0000_61746164;
      4'd1:    kw_text = 48'h0000_65736c65;
      4'd2:    kw_text = 48'h0000_00006e66;
      4'd3:    kw_text = 48'h0065_736c6166;
      4'd4:    kw_text = 48'h0000_00006669;
      4'd5:    kw_text = 48'h0000_0074656c;
      4'd6:    kw_text = 48'h0068_6374616d;
      4'd7:    kw_text = 48'h0000_0074756d;
      4'd8:    kw_text = 48'h6e72_75746572;
      4'd9:    kw_text = 48'h0000_65757274;
      4'd10:   kw_text = 48'h0000_65707974;
      default: kw_text = '0;
    endcase
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    case (k)
      4'd2, 4'd4:              kw_len = 3'd2;
      4'd5, 4'd7:              kw_len = 3'd3;
      4'd0, 4'd1, 4'd9, 4'd10: kw_len = 3'd4;
      4'd3, 4'd6:              kw_len = 3'd5;
      4'd8:                    kw_len = 3'd6;
      default:                 kw_len = 3'd0;
    endcase
  endfunction

  function automatic logic [5:0] op_single(input logic [2:0] p);
    case (p)
      3'd1: op_single = 6'd29;
      3'd2: op_single = 6'd31;
      3'd3: op_single = 6'd34;
      3'd4: op_single = 6'd36;
      3'd5: op_single = 6'd38;
      3'd6: op_single = 6'd40;
      default: op_single = 6'd0;
    endcase
  endfunction

  function automatic logic [7:0] op_second(input logic [2:0] p);
    case (p)
      3'd1, 3'd2, 3'd3, 3'd4: op_second = 8'h3d;
      3'd5: op_second = 8'h26;
      3'd6: op_second = 8'h7c;
      default: op_second = 8'h00;
    endcase
  endfunction

  function automatic logic [5:0] op_pair(input logic [2:0] p);
    op_pair = op_single(p) + 6'd1;
  endfunction

endpackage

// ----- rtl/source_code_token_lexer.sv -----
// ----------------------------------------------------------------------------
// source_code_token_lexer
// byte-stream lexer emitting up to three tokens per input beat
// ----------------------------------------------------------------------------
// output: tokens are registered; the first token beat is valid in the cycle after its input beat is accepted
// throughput: one input beat per cycle while each beat yields at most one token and the output is not stalled;
//   a beat yielding more than one token holds the input until all but its last token have drained
// reset: synchronous, scanner idle, line and column at one, no tokens held
module source_code_token_lexer #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // in_byte
  input  logic        s_tuser,  // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [(16+3*POSITION_WIDTH+7)/8*8-1:0] m_tdata,
  // token_kind, error_code, bad_byte, token_line, token_column, token_length
  output logic        m_tlast   // last_of_run
);
  localparam int PW = POSITION_WIDTH;
  localparam int TW = 16 + 3*PW;
  localparam int DW = (16+3*PW+7)/8*8;
  localparam logic [PW-1:0] PMAX = '1;
  localparam logic [PW-1:0] PONE = PW'(1);

  typedef struct packed {
    logic [PW-1:0] len;
    logic [PW-1:0] col;
    logic [PW-1:0] line;
    logic [7:0]    bad;
    logic [1:0]    err;
    logic [5:0]    kind;
  } tok_t;

  sctl_pkg::mode_t mode, mode_next;
  logic [2:0]    pend, pend_next;
  logic [47:0]   kwp, kwp_next;
  logic [PW-1:0] lexlen, lexlen_next, sline, sline_next, scol, scol_next;
  logic [PW-1:0] cline, cline_next, ccol, ccol_next;

  tok_t       q [3];
  logic [1:0] qn, qh;
  tok_t       t [3];
  logic [1:0] tn;

  logic go;
  assign s_tready = (qn == 2'd0) || (qn == 2'd1 && m_tready);
  assign go = s_tvalid && s_tready;

  function automatic logic [PW-1:0] sinc(input logic [PW-1:0] x);
    sinc = (x == PMAX) ? x : x + PONE;
  endfunction

  function automatic logic [PW-1:0] sadd(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    sadd = s[PW] ? PMAX : s[PW-1:0];
  endfunction

  function automatic tok_t mk(input logic [5:0] k, input logic [1:0] e, input logic [7:0] bb,
                              input logic [PW-1:0] l, input logic [PW-1:0] c,
                              input logic [PW-1:0] n);
    tok_t r;
    r.kind = k; r.err = e; r.bad = bb; r.line = l; r.col = c; r.len = n;
    mk = r;
  endfunction

  logic [7:0] b;
  logic is_al, is_dg, is_id;
  logic [5:0] id_kind;
  logic [3:0] kwi;

  assign b = s_tdata;
  assign is_al = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  assign is_dg = b >= 8'h30 && b <= 8'h39;
  assign is_id = is_al || is_dg || b == 8'h5f;

  always_comb begin
    id_kind = sctl_pkg::K_IDENT;
    for (int k = sctl_pkg::NUM_KW - 1; k >= 0; k--) begin
      kwi = 4'(k);
      if (lexlen == PW'(sctl_pkg::kw_len(kwi)) && kwp == sctl_pkg::kw_text(kwi))
        id_kind = sctl_pkg::K_KW0 + 6'(k);
    end
  end

  always_comb begin
    logic again;
    logic [PW-1:0] ilen;
    logic [5:0] k1;
    again = 1'b0;
    mode_next = mode; pend_next = pend; kwp_next = kwp; lexlen_next = lexlen;
    sline_next = sline; scol_next = scol; cline_next = cline; ccol_next = ccol;
    tn = 2'd0;
    for (int i = 0; i < 3; i++) t[i] = '0;
    ilen = lexlen - PONE;
    k1 = 6'd0;
    if (s_tuser) begin
      unique case (mode)
        sctl_pkg::M_IDENT: begin
          t[0] = mk(id_kind, sctl_pkg::E_NONE, 8'd0, sline, scol, lexlen); tn = 2'd1;
        end
        sctl_pkg::M_INT, sctl_pkg::M_FRAC: begin
          t[0] = mk(sctl_pkg::K_INT, sctl_pkg::E_NONE, 8'd0, sline, scol, lexlen); tn = 2'd1;
        end
        sctl_pkg::M_DOT: begin
          t[0] = mk(sctl_pkg::K_INT, sctl_pkg::E_NONE, 8'd0, sline, scol, ilen);
          t[1] = mk(sctl_pkg::K_DOT, sctl_pkg::E_NONE, 8'd0, sline, sadd(scol, ilen), PONE);
          tn = 2'd2;
        end
        sctl_pkg::M_STR, sctl_pkg::M_ESC: begin
          t[0] = mk(sctl_pkg::K_ERROR, sctl_pkg::E_UNTERM, 8'd0, sline, scol, lexlen);
          tn = 2'd1;
        end
        sctl_pkg::M_SLASH: begin
          t[0] = mk(sctl_pkg::K_SLASH, sctl_pkg::E_NONE, 8'd0, sline, scol, PONE); tn = 2'd1;
        end
        sctl_pkg::M_OP: begin
          if (pend >= 3'd1 && pend <= 3'd6) begin
            t[0] = mk(sctl_pkg::op_single(pend), sctl_pkg::E_NONE, 8'd0, sline, scol, PONE);
            tn = 2'd1;
          end
        end
        default: ;
      endcase
      t[tn] = mk(sctl_pkg::K_EOF, sctl_pkg::E_NONE, 8'd0, cline, ccol, '0);
      tn = tn + 2'd1;
      mode_next = sctl_pkg::M_IDLE; pend_next = '0; kwp_next = '0; lexlen_next = '0;
      sline_next = PONE; scol_next = PONE; cline_next = PONE; ccol_next = PONE;
    end else begin
      unique case (mode)
        sctl_pkg::M_IDENT: begin
          if (is_id) begin
            if (lexlen < PW'(6)) kwp_next = kwp | (48'(b) << {lexlen[2:0], 3'b000});
            lexlen_next = sinc(lexlen);
          end else begin
            t[0] = mk(id_kind, sctl_pkg::E_NONE, 8'd0, sline, scol, lexlen); tn = 2'd1;
            again = 1'b1;
          end
        end
        sctl_pkg::M_INT: begin
          if (is_dg) lexlen_next = sinc(lexlen);
          else if (b == 8'h2e) begin
            lexlen_next = sinc(lexlen); mode_next = sctl_pkg::M_DOT;
          end else begin
            t[0] = mk(sctl_pkg::K_INT, sctl_pkg::E_NONE, 8'd0, sline, scol, lexlen);
            tn = 2'd1; again = 1'b1;
          end
        end
        sctl_pkg::M_DOT: begin
          if (is_dg) begin
            lexlen_next = sinc(lexlen); mode_next = sctl_pkg::M_FRAC;
          end else begin
            t[0] = mk(sctl_pkg::K_INT, sctl_pkg::E_NONE, 8'd0, sline, scol, ilen);
            t[1] = mk(sctl_pkg::K_DOT, sctl_pkg::E_NONE, 8'd0, sline, sadd(scol, ilen), PONE);
            tn = 2'd2; again = 1'b1;
          end
        end
        sctl_pkg::M_FRAC: begin
          if (is_dg) lexlen_next = sinc(lexlen);
          else begin
            t[0] = mk(sctl_pkg::K_INT, sctl_pkg::E_NONE, 8'd0, sline, scol, lexlen);
            tn = 2'd1; again = 1'b1;
          end
        end
        sctl_pkg::M_STR: begin
          lexlen_next = sinc(lexlen);
          if (b == 8'h22) begin
            t[0] = mk(sctl_pkg::K_STRING, sctl_pkg::E_NONE, 8'd0, sline, scol, sinc(lexlen));
            tn = 2'd1; mode_next = sctl_pkg::M_IDLE;
          end else if (b == 8'h5c) mode_next = sctl_pkg::M_ESC;
        end
        sctl_pkg::M_ESC: begin
          lexlen_next = sinc(lexlen); mode_next = sctl_pkg::M_STR;
        end
        sctl_pkg::M_SLASH: begin
          if (b == 8'h2f) mode_next = sctl_pkg::M_LINE;
          else if (b == 8'h2a) mode_next = sctl_pkg::M_BLOCK;
          else begin
            t[0] = mk(sctl_pkg::K_SLASH, sctl_pkg::E_NONE, 8'd0, sline, scol, PONE);
            tn = 2'd1; again = 1'b1;
          end
        end
        sctl_pkg::M_LINE: if (b == 8'h0a) mode_next = sctl_pkg::M_IDLE;
        sctl_pkg::M_BLOCK: if (b == 8'h2a) mode_next = sctl_pkg::M_BSTAR;
        sctl_pkg::M_BSTAR: begin
          if (b == 8'h2f) mode_next = sctl_pkg::M_IDLE;
          else if (b != 8'h2a) mode_next = sctl_pkg::M_BLOCK;
        end
        sctl_pkg::M_OP: begin
          if (pend < 3'd1 || pend > 3'd6) again = 1'b1;
          else if (b == sctl_pkg::op_second(pend)) begin
            t[0] = mk(sctl_pkg::op_pair(pend), sctl_pkg::E_NONE, 8'd0, sline, scol, PW'(2));
            tn = 2'd1; mode_next = sctl_pkg::M_IDLE;
          end else if (pend == 3'd2 && b == 8'h3e) begin
            t[0] = mk(sctl_pkg::K_ARROW, sctl_pkg::E_NONE, 8'd0, sline, scol, PW'(2));
            tn = 2'd1; mode_next = sctl_pkg::M_IDLE;
          end else begin
            t[0] = mk(sctl_pkg::op_single(pend), sctl_pkg::E_NONE, 8'd0, sline, scol, PONE);
            tn = 2'd1; again = 1'b1;
          end
        end
        default: again = 1'b1;
      endcase
      if (again) begin
        mode_next = sctl_pkg::M_IDLE;
        pend_next = '0;
        case (b)
          8'h20, 8'h0d, 8'h09, 8'h0a: k1 = 6'd0;
          8'h28: k1 = 6'd14;
          8'h29: k1 = 6'd15;
          8'h7b: k1 = 6'd16;
          8'h7d: k1 = 6'd17;
          8'h5b: k1 = 6'd18;
          8'h5d: k1 = 6'd19;
          8'h2c: k1 = 6'd20;
          8'h2e: k1 = 6'd21;
          8'h2d: k1 = 6'd22;
          8'h2b: k1 = 6'd23;
          8'h3b: k1 = 6'd24;
          8'h2a: k1 = 6'd25;
          8'h25: k1 = 6'd27;
          8'h3a: k1 = 6'd28;
          8'h21: pend_next = 3'd1;
          8'h3d: pend_next = 3'd2;
          8'h3c: pend_next = 3'd3;
          8'h3e: pend_next = 3'd4;
          8'h26: pend_next = 3'd5;
          8'h7c: pend_next = 3'd6;
          8'h2f: mode_next = sctl_pkg::M_SLASH;
          8'h22: mode_next = sctl_pkg::M_STR;
          default: begin
            if (is_al || b == 8'h5f) mode_next = sctl_pkg::M_IDENT;
            else if (is_dg) mode_next = sctl_pkg::M_INT;
            else k1 = sctl_pkg::K_ERROR;
          end
        endcase
        if (pend_next != 3'd0) mode_next = sctl_pkg::M_OP;
        if (mode_next != sctl_pkg::M_IDLE) begin
          sline_next = cline; scol_next = ccol; lexlen_next = PONE; kwp_next = 48'(b);
        end
        if (k1 != 6'd0) begin
          t[tn] = (k1 == sctl_pkg::K_ERROR)
                ? mk(k1, sctl_pkg::E_CHAR, b, cline, ccol, PONE)
                : mk(k1, sctl_pkg::E_NONE, 8'd0, cline, ccol, PONE);
          tn = tn + 2'd1;
        end
      end
      if (mode_next == sctl_pkg::M_IDLE) pend_next = '0;
      if (b == 8'h0a) begin
        cline_next = sinc(cline); ccol_next = PONE;
      end else ccol_next = sinc(ccol);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sctl_pkg::M_IDLE; pend <= '0; kwp <= '0; lexlen <= '0;
      sline <= PONE; scol <= PONE; cline <= PONE; ccol <= PONE;
      qn <= '0; qh <= '0;
    end else if (go) begin
      mode <= mode_next; pend <= pend_next; kwp <= kwp_next; lexlen <= lexlen_next;
      sline <= sline_next; scol <= scol_next; cline <= cline_next; ccol <= ccol_next;
      qn <= tn; qh <= '0;
    end else if (m_tvalid && m_tready) begin
      qn <= qn - 2'd1; qh <= qh + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) for (int i = 0; i < 3; i++) q[i] <= t[i];
  end

  tok_t cur;
  assign cur = q[qh];
  assign m_tvalid = qn != 2'd0;
  assign m_tlast = qn == 2'd1;
  assign m_tdata = DW'(TW'(cur));
endmodule

// ----- test/source_code_token_lexer_checker.sv -----
// ----------------------------------------------------------------------------
// source_code_token_lexer_checker
// watches the byte and token streams, predicts the tokens of every accepted
// byte and compares each token beat field by field, in order
// ----------------------------------------------------------------------------
module source_code_token_lexer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending_tokens,
  output int          token_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [7:0]  bad;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } token_t;

  localparam logic [15:0] PMAX = 16'hffff;

  token_t          token_q[$];
  token_t          run_q[$];
  sctl_pkg::mode_t mode;
  logic [2:0]      op_sel;
  logic [47:0]     prefix;
  logic [15:0]     lex_len, st_line, st_col, cur_line, cur_col;

  function automatic logic [15:0] sinc(logic [15:0] x);
    return (x == PMAX) ? PMAX : x + 16'd1;
  endfunction

  function automatic logic [15:0] sadd(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? PMAX : s[15:0];
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic push_tok(logic [5:0] k, logic [1:0] e, logic [7:0] b,
                          logic [15:0] l, logic [15:0] c, logic [15:0] n);
    token_t t;
    t = '{kind: k, err: e, bad: b, line: l, col: c, len: n, last: 1'b0};
    if (run_q.size() < 3) run_q.push_back(t);
  endtask

  task automatic begin_tok(sctl_pkg::mode_t m, logic [7:0] b);
    mode = m;
    st_line = cur_line;
    st_col = cur_col;
    lex_len = 16'd1;
    prefix = {40'd0, b};
  endtask

  task automatic finish_word();
    logic [5:0] k;
    k = sctl_pkg::K_IDENT;
    for (int i = 0; i < sctl_pkg::NUM_KW; i++) begin
      if (lex_len == 16'(sctl_pkg::kw_len(4'(i))) && prefix == sctl_pkg::kw_text(4'(i))) begin
        k = sctl_pkg::K_KW0 + 6'(i);
        break;
      end
    end
    push_tok(k, sctl_pkg::E_NONE, 8'd0, st_line, st_col, lex_len);
  endtask

  task automatic finish_num_dot();
    push_tok(sctl_pkg::K_INT, sctl_pkg::E_NONE, 8'd0, st_line, st_col, lex_len - 16'd1);
    push_tok(sctl_pkg::K_DOT, sctl_pkg::E_NONE, 8'd0, st_line,
             sadd(st_col, lex_len - 16'd1), 16'd1);
  endtask

  task automatic scan_fresh(logic [7:0] b);
    logic [5:0] k;
    k = sctl_pkg::K_ERROR;
    case (b)
      8'h20, 8'h0d, 8'h09, 8'h0a: return;
      "(": k = 6'd14;
      ")": k = 6'd15;
      "{": k = 6'd16;
      "}": k = 6'd17;
      "[": k = 6'd18;
      "]": k = 6'd19;
      ",": k = 6'd20;
      ".": k = sctl_pkg::K_DOT;
      "-": k = 6'd22;
      "+": k = 6'd23;
      ";": k = 6'd24;
      "*": k = 6'd25;
      "%": k = 6'd27;
      ":": k = 6'd28;
      "!": begin op_sel = 3'd1; begin_tok(sctl_pkg::M_OP, b); return; end
      "=": begin op_sel = 3'd2; begin_tok(sctl_pkg::M_OP, b); return; end
      "<": begin op_sel = 3'd3; begin_tok(sctl_pkg::M_OP, b); return; end
      ">": begin op_sel = 3'd4; begin_tok(sctl_pkg::M_OP, b); return; end
      "&": begin op_sel = 3'd5; begin_tok(sctl_pkg::M_OP, b); return; end
      "|": begin op_sel = 3'd6; begin_tok(sctl_pkg::M_OP, b); return; end
      "/": begin begin_tok(sctl_pkg::M_SLASH, b); return; end
      8'h22: begin begin_tok(sctl_pkg::M_STR, b); return; end
      default: begin
        if (is_alpha(b) || b == "_") begin begin_tok(sctl_pkg::M_IDENT, b); return; end
        if (is_digit(b)) begin begin_tok(sctl_pkg::M_INT, b); return; end
      end
    endcase
    if (k == sctl_pkg::K_ERROR)
      push_tok(sctl_pkg::K_ERROR, sctl_pkg::E_CHAR, b, cur_line, cur_col, 16'd1);
    else push_tok(k, sctl_pkg::E_NONE, 8'd0, cur_line, cur_col, 16'd1);
  endtask

  task automatic clear_scan();
    mode = sctl_pkg::M_IDLE;
    op_sel = '0;
    prefix = '0;
    lex_len = '0;
    st_line = 16'd1;
    st_col = 16'd1;
    cur_line = 16'd1;
    cur_col = 16'd1;
  endtask

  task automatic lex_byte(logic [7:0] b);
    logic rescan;
    rescan = 1'b0;
    case (mode)
      sctl_pkg::M_IDENT:
        if (is_alpha(b) || is_digit(b) || b == "_") begin
          if (lex_len < 16'd6) prefix[8*lex_len[2:0] +: 8] = b;
          lex_len = sinc(lex_len);
        end else begin
          finish_word();
          rescan = 1'b1;
        end
      sctl_pkg::M_INT:
        if (is_digit(b)) lex_len = sinc(lex_len);
        else if (b == ".") begin
          lex_len = sinc(lex_len);
          mode = sctl_pkg::M_DOT;
        end else begin
          push_tok(sctl_pkg::K_INT, sctl_pkg::E_NONE, 8'd0, st_line, st_col, lex_len);
          rescan = 1'b1;
        end
      sctl_pkg::M_DOT:
        if (is_digit(b)) begin
          lex_len = sinc(lex_len);
          mode = sctl_pkg::M_FRAC;
        end else begin
          finish_num_dot();
          rescan = 1'b1;
        end
      sctl_pkg::M_FRAC:
        if (is_digit(b)) lex_len = sinc(lex_len);
        else begin
          push_tok(sctl_pkg::K_INT, sctl_pkg::E_NONE, 8'd0, st_line, st_col, lex_len);
          rescan = 1'b1;
        end
      sctl_pkg::M_STR: begin
        lex_len = sinc(lex_len);
        if (b == 8'h22) begin
          push_tok(sctl_pkg::K_STRING, sctl_pkg::E_NONE, 8'd0, st_line, st_col, lex_len);
          mode = sctl_pkg::M_IDLE;
        end else if (b == 8'h5c) mode = sctl_pkg::M_ESC;
      end
      sctl_pkg::M_ESC: begin
        lex_len = sinc(lex_len);
        mode = sctl_pkg::M_STR;
      end
      sctl_pkg::M_SLASH:
        if (b == "/") mode = sctl_pkg::M_LINE;
        else if (b == "*") mode = sctl_pkg::M_BLOCK;
        else begin
          push_tok(sctl_pkg::K_SLASH, sctl_pkg::E_NONE, 8'd0, st_line, st_col, 16'd1);
          rescan = 1'b1;
        end
      sctl_pkg::M_LINE:  if (b == 8'h0a) mode = sctl_pkg::M_IDLE;
      sctl_pkg::M_BLOCK: if (b == "*") mode = sctl_pkg::M_BSTAR;
      sctl_pkg::M_BSTAR:
        if (b == "/") mode = sctl_pkg::M_IDLE;
        else if (b != "*") mode = sctl_pkg::M_BLOCK;
      sctl_pkg::M_OP:
        if (b == sctl_pkg::op_second(op_sel)) begin
          push_tok(sctl_pkg::op_pair(op_sel), sctl_pkg::E_NONE, 8'd0, st_line, st_col, 16'd2);
          mode = sctl_pkg::M_IDLE;
        end else if (op_sel == 3'd2 && b == ">") begin
          push_tok(sctl_pkg::K_ARROW, sctl_pkg::E_NONE, 8'd0, st_line, st_col, 16'd2);
          mode = sctl_pkg::M_IDLE;
        end else begin
          push_tok(sctl_pkg::op_single(op_sel), sctl_pkg::E_NONE, 8'd0, st_line, st_col,
                   16'd1);
          rescan = 1'b1;
        end
      default: rescan = 1'b1;
    endcase
    if (rescan) begin
      mode = sctl_pkg::M_IDLE;
      op_sel = '0;
      scan_fresh(b);
    end
    if (mode == sctl_pkg::M_IDLE) op_sel = '0;
    if (b == 8'h0a) begin
      cur_line = sinc(cur_line);
      cur_col = 16'd1;
    end else cur_col = sinc(cur_col);
  endtask

  task automatic lex_end();
    case (mode)
      sctl_pkg::M_IDENT: finish_word();
      sctl_pkg::M_INT, sctl_pkg::M_FRAC:
        push_tok(sctl_pkg::K_INT, sctl_pkg::E_NONE, 8'd0, st_line, st_col, lex_len);
      sctl_pkg::M_DOT: finish_num_dot();
      sctl_pkg::M_STR, sctl_pkg::M_ESC:
        push_tok(sctl_pkg::K_ERROR, sctl_pkg::E_UNTERM, 8'd0, st_line, st_col, lex_len);
      sctl_pkg::M_SLASH:
        push_tok(sctl_pkg::K_SLASH, sctl_pkg::E_NONE, 8'd0, st_line, st_col, 16'd1);
      sctl_pkg::M_OP:
        push_tok(sctl_pkg::op_single(op_sel), sctl_pkg::E_NONE, 8'd0, st_line, st_col, 16'd1);
      default: ;
    endcase
    push_tok(sctl_pkg::K_EOF, sctl_pkg::E_NONE, 8'd0, cur_line, cur_col, 16'd0);
    clear_scan();
  endtask

  function automatic string tok_str(token_t t);
    return $sformatf("kind %0d err %0d bad %0d %0d:%0d len %0d last %0d",
                     t.kind, t.err, t.bad, t.line, t.col, t.len, t.last);
  endfunction

  task automatic report_mismatch(string what, token_t got, token_t want);
    $display("mismatch %s: got %s, want %s", what, tok_str(got), tok_str(want));
    fail_count = fail_count + 1;
  endtask

  assign pending_tokens = token_q.size();

  always @(posedge clk) begin
    token_t got, want;
    if (rst) begin
      clear_scan();
      token_q.delete();
      fail_count = 0;
      token_count <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{kind: m_tdata[5:0], err: m_tdata[7:6], bad: m_tdata[15:8],
                line: m_tdata[31:16], col: m_tdata[47:32], len: m_tdata[63:48],
                last: m_tlast};
        token_count <= token_count + 1;
        if (token_q.size() == 0) report_mismatch("unexpected beat", got, got);
        else begin
          want = token_q.pop_front();
          if (got != want) report_mismatch("token", got, want);
        end
      end
      if (s_tvalid && s_tready) begin
        run_q.delete();
        if (s_tuser) lex_end();
        else lex_byte(s_tdata);
        if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
        foreach (run_q[i]) token_q.push_back(run_q[i]);
      end
    end
  end

endmodule

// ----- test/source_code_token_lexer_tb.sv -----
// ----------------------------------------------------------------------------
// source_code_token_lexer_tb
// drives source text through the lexer: directed snippets of tokens, block
// comments, errors and end-of-file cases, then random program-like text
// and byte noise under varying valid and ready idling
// ----------------------------------------------------------------------------
module source_code_token_lexer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 60000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;
  int          fail_count, pending_tokens, token_count;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          byte_count = 0;
  int          cycle_count = 0;
  logic        hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  source_code_token_lexer u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  source_code_token_lexer_checker u_chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .fail_count, .pending_tokens, .token_count
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(logic [7:0] b, logic eoi);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= eoi;
    byte_count++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_item(s[i], 1'b0);
  endtask

  task automatic send_eof();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_tokens != 0) @(posedge clk);
  endtask

  function automatic string pick_piece();
    string words[] = '{"data", "else", "fn", "false", "if", "let", "match", "mut",
                       "return", "true", "type", "x", "_a9", "returns", "Fnx",
                       "42", "3.14", "7.", "0", "\"hi\\\"\"", "\"a\nb\"",
                       "(", ")", "{", "}", "[", "]", ",", ".", "-", "+", ";", "*",
                       "/", "%", ":", "!", "!=", "=", "==", "=>", "<", "<=", ">",
                       ">=", "&", "&&", "|", "||", "// c\n", "/* b ** */",
                       " ", "\n", "\t", "\015", "@", "#"};
    return words[$urandom_range(words.size() - 1)];
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) begin
        send_text(pick_piece());
        if ($urandom_range(1)) send_item(" ", 1'b0);
      end else send_item(8'($urandom_range(255)), 1'b0);
      if ($urandom_range(99) < 4) send_eof();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // directed
    send_text("let x=a1&&b||!c;");
    send_eof();
    send_text("3.a 1.5 \"q\\\"\n\"/*x*/");
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h80, 1'b0);
    send_eof();
    send_text("\"open");
    send_eof();
    send_text("/* open");
    send_eof();
    send_text("==>=<=");
    send_eof();
    send_text("9.");
    send_eof();
    send_eof();
    drain();
    // long receiver hold-off while the sender keeps offering bytes
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 20; i++) send_text("( ");
      end
    join
    drain();
    random_phase(28, 0, 0);
    random_phase(28, 73, 0);
    random_phase(28, 0, 73);
    random_phase(28, 7, 7);
    drain();
    random_phase(28, 0, 0);
    send_eof();
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d input beats and %0d token beats across every token class,",
             byte_count, token_count);
    $display("comments, errors and end-of-file under sender and receiver idling");
    if (fail_count == 0 && pending_tokens == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
